[src/psbm_pkg.sv]
// Shared constants, types and helpers for the patch SSD best-match block.
`default_nettype none

package psbm_pkg;

    // Configuration of the datapath
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_IMAGE_DIM = 4096;

    // Fixed field widths
    localparam int COORD_W  = 12;
    localparam int SAMPLE_W = 16;
    localparam int DIST_W   = 48;
    localparam int SQ_W     = 2 * SAMPLE_W;

    // Sample bits kept from the 16-bit port
    localparam int SAMPLE_KEEP = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((64'd1 << SAMPLE_KEEP) - 64'd1);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [31:0] COORD_LIM = 32'(MAX_IMAGE_DIM - 1);

    // Request type codes
    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req_type;

    // Payload held between the input stage and the scoring stage
    typedef struct packed {
        logic                is_load;
        logic [COORD_W-1:0]  load_x;
        logic [COORD_W-1:0]  load_y;
        logic [DIST_W-1:0]   load_dist;
        logic [SQ_W-1:0]     sq;
        logic [COORD_W-1:0]  cand_x;
        logic [COORD_W-1:0]  cand_y;
        logic                column_end;
        logic                patch_end;
    } t_stage;

    // Clamp a coordinate to the image size
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide > COORD_LIM) begin
            wide = COORD_LIM;
        end
        return wide[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/psbm_if.sv]
// Request and result channel interfaces of the patch SSD best-match block.
`default_nettype none

interface psbm_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [psbm_pkg::COORD_W-1:0]  load_x;
    logic [psbm_pkg::COORD_W-1:0]  load_y;
    logic [psbm_pkg::DIST_W-1:0]   load_dist;
    logic [psbm_pkg::SAMPLE_W-1:0] a_sample;
    logic [psbm_pkg::SAMPLE_W-1:0] b_sample;
    logic [psbm_pkg::COORD_W-1:0]  cand_x;
    logic [psbm_pkg::COORD_W-1:0]  cand_y;
    logic                          column_end;
    logic                          patch_end;

    modport source (
        output valid, req_type, load_x, load_y, load_dist, a_sample, b_sample,
               cand_x, cand_y, column_end, patch_end,
        input  ready
    );
    modport sink (
        input  valid, req_type, load_x, load_y, load_dist, a_sample, b_sample,
               cand_x, cand_y, column_end, patch_end,
        output ready
    );
endinterface

interface psbm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [psbm_pkg::COORD_W-1:0] best_x;
    logic [psbm_pkg::COORD_W-1:0] best_y;
    logic [psbm_pkg::DIST_W-1:0]  best_dist;
    logic                         improved;

    modport source (
        output valid, best_x, best_y, best_dist, improved,
        input  ready
    );
    modport sink (
        input  valid, best_x, best_y, best_dist, improved,
        output ready
    );
endinterface

`default_nettype wire

[src/patch_ssd_best_match.sv]
// Top level: patch SSD scoring with column cutoff and best-match tracking.
// A patch-end request's result is registered in the result register when it leaves the input stage.
// Throughput: one request per cycle unless the scoring stage stalls; the square is registered in the input stage and
// the 48-bit add and compare run in the scoring stage, which holds a patch end while
// an earlier result still waits on the output.
// Reset (synchronous, active low): stages empty, best distance all ones, sum cleared.
`default_nettype none

module patch_ssd_best_match (
    input  wire             i_clk,
    input  wire             i_rst_n,
    psbm_req_if.sink        i_req,
    psbm_rsp_if.source      o_rsp
);

    localparam int COORD_W  = psbm_pkg::COORD_W;
    localparam int SAMPLE_W = psbm_pkg::SAMPLE_W;
    localparam int DIST_W   = psbm_pkg::DIST_W;
    localparam int SQ_W     = psbm_pkg::SQ_W;

    // Input stage register
    logic                r_s1_valid;
    psbm_pkg::t_stage    r_s1;
    psbm_pkg::t_stage    n_s1;

    // Best match and running state
    logic [COORD_W-1:0]  r_best_x, n_best_x;
    logic [COORD_W-1:0]  r_best_y, n_best_y;
    logic [DIST_W-1:0]   r_best_dist, n_best_dist;
    logic [DIST_W-1:0]   r_sum, n_sum;
    logic                r_cut, n_cut;

    // Result register
    logic                r_out_valid;
    logic [COORD_W-1:0]  r_out_x;
    logic [COORD_W-1:0]  r_out_y;
    logic [DIST_W-1:0]   r_out_dist;
    logic                r_out_improved;

    logic                adv2;
    logic                in_accept;
    logic [SAMPLE_W-1:0] a_m, b_m, diff;
    logic [DIST_W:0]     sum_add;
    logic [DIST_W-1:0]   sum_sat;
    logic                ge_best;
    logic                better;

    // Handshake: scoring stage moves unless a result would overwrite a held one
    assign adv2 = r_s1_valid && (!r_s1.patch_end || r_s1.is_load || !r_out_valid
                                 || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || adv2;
    assign in_accept   = i_req.valid && i_req.ready;

    // Input stage: absolute difference and its square
    always_comb begin
        a_m  = i_req.a_sample & psbm_pkg::SAMPLE_MASK;
        b_m  = i_req.b_sample & psbm_pkg::SAMPLE_MASK;
        diff = (a_m >= b_m) ? (a_m - b_m) : (b_m - a_m);
        n_s1.is_load    = (i_req.req_type == psbm_pkg::REQ_LOAD);
        n_s1.load_x     = psbm_pkg::clamp_coord(i_req.load_x);
        n_s1.load_y     = psbm_pkg::clamp_coord(i_req.load_y);
        n_s1.load_dist  = i_req.load_dist;
        n_s1.sq         = SQ_W'(diff) * SQ_W'(diff);
        n_s1.cand_x     = psbm_pkg::clamp_coord(i_req.cand_x);
        n_s1.cand_y     = psbm_pkg::clamp_coord(i_req.cand_y);
        n_s1.column_end = i_req.column_end;
        n_s1.patch_end  = i_req.patch_end;
    end

    // Scoring stage: best-match load, or saturating accumulate, cutoff and best update
    always_comb begin
        sum_add     = {1'b0, r_sum} + (DIST_W+1)'(r_s1.sq);
        sum_sat     = r_cut ? r_sum
                    : (sum_add[DIST_W] ? psbm_pkg::DIST_MAX : sum_add[DIST_W-1:0]);
        ge_best     = (sum_sat >= r_best_dist);
        better      = !r_cut && !ge_best;
        n_best_x    = r_best_x;
        n_best_y    = r_best_y;
        n_best_dist = r_best_dist;
        n_sum       = sum_sat;
        n_cut       = r_cut || (r_s1.column_end && ge_best);
        if (r_s1.is_load) begin
            n_best_x    = r_s1.load_x;
            n_best_y    = r_s1.load_y;
            n_best_dist = r_s1.load_dist;
            n_sum       = '0;
            n_cut       = 1'b0;
        end else if (r_s1.patch_end) begin
            if (better) begin
                n_best_x    = r_s1.cand_x;
                n_best_y    = r_s1.cand_y;
                n_best_dist = sum_sat;
            end
            n_sum = '0;
            n_cut = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_dist <= psbm_pkg::DIST_MAX;
            r_sum       <= '0;
            r_cut       <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv2) begin
                r_s1_valid <= 1'b0;
            end
            if (adv2) begin
                r_best_x    <= n_best_x;
                r_best_y    <= n_best_y;
                r_best_dist <= n_best_dist;
                r_sum       <= n_sum;
                r_cut       <= n_cut;
            end
            if (adv2 && !r_s1.is_load && r_s1.patch_end) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
        if (adv2 && !r_s1.is_load && r_s1.patch_end) begin
            r_out_x        <= n_best_x;
            r_out_y        <= n_best_y;
            r_out_dist     <= n_best_dist;
            r_out_improved <= better;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.best_x    = r_out_x;
    assign o_rsp.best_y    = r_out_y;
    assign o_rsp.best_dist = r_out_dist;
    assign o_rsp.improved  = r_out_improved;

    // A cut-off candidate has reached the best distance
    a_cut_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut |-> (r_sum >= r_best_dist))
        else $error("cutoff set while sum below best distance");

    // Patch end leaves a clean accumulator
    a_patch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && !r_s1.is_load && r_s1.patch_end) |=> (r_sum == '0 && !r_cut))
        else $error("accumulator not cleared after patch end");

    // Improved flag matches a change of the best distance
    a_improved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && !r_s1.is_load && r_s1.patch_end)
        |=> (o_rsp.improved == (r_best_dist < $past(r_best_dist))))
        else $error("improved flag disagrees with best distance");

    // A stalled input stage keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv2) |=> (r_s1_valid && $stable(r_s1)))
        else $error("input stage request lost while stalled");

endmodule

`default_nettype wire
